[design/srs_pkg.sv]
// ----------------------------------------------------------------------------
// srs_pkg
// Shared types and constants for the selective-repeat receive scoreboard.
// ----------------------------------------------------------------------------
package srs_pkg;

    // default map size and reset request size
    localparam int SLOTS_DEFAULT = 255;
    localparam logic [4:0] IPR_RESET = 5'd28;

    // map memory word width
    localparam int WORD_W = 32;

    // config register byte address
    localparam logic [0:0] ADDR_IPR = 1'b0;

    // request codes
    typedef enum logic [1:0] {
        REQ_DATA  = 2'd0,
        REQ_COUNT = 2'd1,
        REQ_NEXT  = 2'd2,
        REQ_CLEAR = 2'd3
    } req_type_t;

    // sequencer states, one-hot
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SLOT = 6'b000010,
        S_RD   = 6'b000100,
        S_ACC  = 6'b001000,
        S_DIV  = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

endpackage

[design/srs_in_if.sv]
// ----------------------------------------------------------------------------
// srs_in_if
// Request channel: one request word per valid/ready handshake.
// ----------------------------------------------------------------------------
interface srs_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] pkt_id;

    modport source (output valid, output req_type, output pkt_id, input ready);
    modport sink (input valid, input req_type, input pkt_id, output ready);
endinterface

[design/srs_out_if.sv]
// ----------------------------------------------------------------------------
// srs_out_if
// Result channel: one result word per valid/ready handshake.
// ----------------------------------------------------------------------------
interface srs_out_if;
    logic       valid;
    logic       ready;
    logic       accepted;
    logic       duplicate;
    logic [7:0] missing_id;
    logic [4:0] slot_in_request;
    logic       request_last;
    logic       list_done;
    logic [7:0] missing_count;
    logic [7:0] missing_below_highest;
    logic [7:0] request_count;
    logic [7:0] highest_id;

    modport source (
        output valid, output accepted, output duplicate, output missing_id,
        output slot_in_request, output request_last, output list_done,
        output missing_count, output missing_below_highest, output request_count,
        output highest_id, input ready
    );
    modport sink (
        input valid, input accepted, input duplicate, input missing_id,
        input slot_in_request, input request_last, input list_done,
        input missing_count, input missing_below_highest, input request_count,
        input highest_id, output ready
    );
endinterface

[design/selective_repeat_rx_scoreboard.sv]
// ----------------------------------------------------------------------------
// selective_repeat_rx_scoreboard
// Receive bitmap for one block of numbered packets, with count and
// next-missing queries over a word-organized map memory.
// ----------------------------------------------------------------------------
// The receive map lives in a synchronous memory of ceil(SLOTS/32) words of 32
// bits, with one valid flop per word so a block reset clears it by clearing the
// flops. One request word is worked on at a time. A data arrival passes slot
// modulo, map read, update and write, and result. A next-missing query sweeps
// the map one word at a time, each word with a read and an accumulate step; a
// count query does the same sweep and then a bit-serial division for the
// request count. A block reset goes straight to the result. The result sits
// in an output register, so the next request word is taken while a result
// still waits.
// ----------------------------------------------------------------------------
module selective_repeat_rx_scoreboard
    import srs_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    srs_in_if.sink      req,
    srs_out_if.source   rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int WORDS  = (SLOTS + WORD_W - 1) / WORD_W;
    localparam int WIDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int RECIP  = 65536 / SLOTS;

    // map bit b of word w counts as a slot when it is in 1..SLOTS-1
    function automatic logic [31:0] live_mask(input logic [WIDX_W-1:0] w);
        logic [31:0] m;
        logic [8:0]  s;
        for (int b = 0; b < WORD_W; b++) begin
            s    = 9'({w, 5'(b)});
            m[b] = (s != 9'd0) && (s < 9'(SLOTS));
        end
        return m;
    endfunction

    // bits whose slot lies strictly above the cursor
    function automatic logic [31:0] above_mask(input logic [WIDX_W-1:0] w,
                                               input logic [7:0] cur);
        logic [31:0] m;
        logic [8:0]  s;
        for (int b = 0; b < WORD_W; b++) begin
            s    = 9'({w, 5'(b)});
            m[b] = s > {1'b0, cur};
        end
        return m;
    endfunction

    // bits whose slot lies at or below the highest id
    function automatic logic [31:0] upto_mask(input logic [WIDX_W-1:0] w,
                                              input logic [7:0] hi);
        logic [31:0] m;
        logic [8:0]  s;
        for (int b = 0; b < WORD_W; b++) begin
            s    = 9'({w, 5'(b)});
            m[b] = s <= {1'b0, hi};
        end
        return m;
    endfunction

    // control and block state
    state_t            state_reg;
    req_type_t         op_reg;
    logic [WORDS-1:0]  word_valid_reg;
    logic [WIDX_W-1:0] w_reg;
    logic [3:0]        div_cnt_reg;
    logic [7:0]        highest_reg;
    logic [7:0]        cursor_reg;
    logic [4:0]        pos_reg;
    logic [4:0]        ipr_reg;
    logic              rsp_valid_reg;
    logic              rd_valid_reg;

    // datapath registers
    logic [7:0]        id_reg;
    logic [7:0]        quot_reg;
    logic [7:0]        slot_reg;
    logic [31:0]       rd_data_reg;
    logic              acc_reg;
    logic              dup_reg;
    logic [7:0]        mc_reg;
    logic [7:0]        mbh_reg;
    logic              found_reg;
    logic              second_reg;
    logic [7:0]        s_reg;
    logic [8:0]        dvd_reg;
    logic [4:0]        rem_reg;
    logic [8:0]        q_reg;

    // output registers
    logic              out_acc_reg;
    logic              out_dup_reg;
    logic [7:0]        out_mid_reg;
    logic [4:0]        out_sir_reg;
    logic              out_rlast_reg;
    logic              out_done_reg;
    logic [7:0]        out_mc_reg;
    logic [7:0]        out_mbh_reg;
    logic [7:0]        out_rc_reg;
    logic [7:0]        out_high_reg;

    // map memory
    logic [31:0]       map_mem [WORDS];

    logic              req_fire;
    logic              cfg_wr;
    logic [4:0]        ipr;
    logic [23:0]       recip_prod;
    logic [8:0]        rem_raw;
    logic [8:0]        slot_fix;
    logic [WIDX_W-1:0] mem_addr;
    logic              rd_en;
    logic              wr_en;
    logic [31:0]       rd_word;
    logic [31:0]       wr_word;
    logic              bit_set;
    logic              sweep_last;
    logic [31:0]       miss;
    logic [31:0]       cand;
    logic [7:0]        mc_next;
    logic [7:0]        mbh_next;
    logic [4:0]        cand_low;
    logic [5:0]        div_trial;
    logic              div_take;
    logic              load_out;
    logic              list_end;
    logic              req_end;

    assign req_fire = req.valid && req.ready;
    assign cfg_wr   = psel && penable && pwrite && (paddr == ADDR_IPR);
    assign ipr      = (ipr_reg == 5'd0) ? 5'd1 : ipr_reg;

    // APB read side
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_IPR) ? {27'd0, ipr_reg} : 32'd0;

    // slot = id mod SLOTS by reciprocal, then one correction
    assign recip_prod = 24'(req.pkt_id) * 24'(RECIP);
    assign rem_raw    = {1'b0, id_reg} - 9'(16'(quot_reg) * 16'(SLOTS));
    assign slot_fix   = (rem_raw >= 9'(SLOTS)) ? rem_raw - 9'(SLOTS) : rem_raw;

    // map access
    assign mem_addr = (op_reg == REQ_DATA) ? slot_reg[5 +: WIDX_W] : w_reg;
    assign rd_en    = (state_reg == S_RD);
    assign rd_word  = rd_valid_reg ? rd_data_reg : 32'd0;
    assign bit_set  = rd_word[slot_reg[4:0]];
    assign wr_en    = (state_reg == S_ACC) && (op_reg == REQ_DATA) && !bit_set;
    assign wr_word  = rd_word | (32'd1 << slot_reg[4:0]);

    // per-word sweep terms
    assign sweep_last = (w_reg == WIDX_W'(WORDS - 1));
    assign miss       = ~rd_word & live_mask(w_reg);
    assign cand       = miss & above_mask(w_reg, cursor_reg);
    assign mc_next    = mc_reg + 8'($countones(miss));
    assign mbh_next   = mbh_reg + 8'($countones(miss & upto_mask(w_reg, highest_reg)));

    // lowest candidate bit
    always_comb
    begin
        cand_low = 5'd0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (cand[b])
            begin
                cand_low = 5'(b);
            end
        end
    end

    // one restoring division step
    assign div_trial = {rem_reg, dvd_reg[8]};
    assign div_take  = div_trial >= {1'b0, ipr};

    // next-missing answer terms
    assign list_end = !second_reg;
    assign req_end  = list_end || ({1'b0, pos_reg} + 6'd1 >= {1'b0, ipr});
    assign load_out = (state_reg == S_DONE) && (!rsp_valid_reg || rsp.ready);

    assign req.ready = (state_reg == S_IDLE);

    // sequencer and block state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= REQ_DATA;
            word_valid_reg <= '0;
            w_reg          <= '0;
            div_cnt_reg    <= 4'd0;
            highest_reg    <= 8'd0;
            cursor_reg     <= 8'd0;
            pos_reg        <= 5'd0;
            ipr_reg        <= IPR_RESET;
            rsp_valid_reg  <= 1'b0;
            rd_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                ipr_reg <= pwdata[4:0];
            end
            if (rd_en)
            begin
                rd_valid_reg <= word_valid_reg[mem_addr];
            end
            if (wr_en)
            begin
                word_valid_reg[mem_addr] <= 1'b1;
            end
            if (load_out)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (req_fire)
                    begin
                        op_reg <= req_type_t'(req.req_type);
                        w_reg  <= '0;
                        case (req_type_t'(req.req_type))
                            REQ_DATA:  state_reg <= S_SLOT;
                            REQ_COUNT: state_reg <= S_RD;
                            REQ_NEXT:  state_reg <= S_RD;
                            default:
                            begin
                                // block reset: drop the map and the walk
                                word_valid_reg <= '0;
                                highest_reg    <= 8'd0;
                                cursor_reg     <= 8'd0;
                                pos_reg        <= 5'd0;
                                state_reg      <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SLOT:
                begin
                    state_reg <= S_RD;
                end
                S_RD:
                begin
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    if (op_reg == REQ_DATA)
                    begin
                        if (!bit_set && (id_reg > highest_reg))
                        begin
                            highest_reg <= id_reg;
                        end
                        state_reg <= S_DONE;
                    end
                    else if (!sweep_last)
                    begin
                        w_reg     <= w_reg + WIDX_W'(1);
                        state_reg <= S_RD;
                    end
                    else if (op_reg == REQ_COUNT)
                    begin
                        div_cnt_reg <= 4'd0;
                        state_reg   <= S_DIV;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DIV:
                begin
                    div_cnt_reg <= div_cnt_reg + 4'd1;
                    if (div_cnt_reg == 4'd8)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (load_out)
                    begin
                        // advance or rewind the walk
                        if (op_reg == REQ_COUNT)
                        begin
                            cursor_reg <= 8'd0;
                            pos_reg    <= 5'd0;
                        end
                        else if ((op_reg == REQ_NEXT) && found_reg)
                        begin
                            cursor_reg <= s_reg;
                            pos_reg    <= req_end ? 5'd0 : pos_reg + 5'd1;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // map memory, one read or write port use per cycle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= map_mem[mem_addr];
        end
        if (wr_en)
        begin
            map_mem[mem_addr] <= wr_word;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                id_reg     <= req.pkt_id;
                quot_reg   <= recip_prod[23:16];
                acc_reg    <= 1'b0;
                dup_reg    <= 1'b0;
                mc_reg     <= 8'd0;
                mbh_reg    <= 8'd0;
                found_reg  <= 1'b0;
                second_reg <= 1'b0;
                s_reg      <= 8'd0;
                q_reg      <= 9'd0;
            end
            S_SLOT:
            begin
                slot_reg <= slot_fix[7:0];
            end
            S_ACC:
            begin
                acc_reg <= !bit_set;
                dup_reg <= bit_set;
                mc_reg  <= mc_next;
                mbh_reg <= mbh_next;
                // keep the first missing slot and note any one after it
                if (!found_reg)
                begin
                    if (cand != 32'd0)
                    begin
                        found_reg  <= 1'b1;
                        s_reg      <= 8'({w_reg, cand_low});
                        second_reg <= (cand & (cand - 32'd1)) != 32'd0;
                    end
                end
                else if (cand != 32'd0)
                begin
                    second_reg <= 1'b1;
                end
                // load the rounded-up dividend
                dvd_reg <= 9'(mc_next) + 9'(ipr) - 9'd1;
                rem_reg <= 5'd0;
            end
            S_DIV:
            begin
                dvd_reg <= {dvd_reg[7:0], 1'b0};
                q_reg   <= {q_reg[7:0], div_take};
                rem_reg <= div_take ? 5'(div_trial - {1'b0, ipr}) : div_trial[4:0];
            end
            default:
            begin
            end
        endcase
    end

    // result word
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_acc_reg   <= 1'b0;
            out_dup_reg   <= 1'b0;
            out_mid_reg   <= 8'd0;
            out_sir_reg   <= 5'd0;
            out_rlast_reg <= 1'b0;
            out_done_reg  <= 1'b0;
            out_mc_reg    <= 8'd0;
            out_mbh_reg   <= 8'd0;
            out_rc_reg    <= 8'd0;
            out_high_reg  <= highest_reg;
            case (op_reg)
                REQ_DATA:
                begin
                    out_acc_reg <= acc_reg;
                    out_dup_reg <= dup_reg;
                end
                REQ_COUNT:
                begin
                    out_mc_reg  <= mc_reg;
                    out_mbh_reg <= mbh_reg;
                    out_rc_reg  <= q_reg[7:0];
                end
                REQ_NEXT:
                begin
                    if (found_reg)
                    begin
                        out_mid_reg   <= s_reg;
                        out_sir_reg   <= pos_reg;
                        out_rlast_reg <= req_end;
                        out_done_reg  <= list_end;
                    end
                    else
                    begin
                        out_done_reg <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign rsp.valid                 = rsp_valid_reg;
    assign rsp.accepted              = out_acc_reg;
    assign rsp.duplicate             = out_dup_reg;
    assign rsp.missing_id            = out_mid_reg;
    assign rsp.slot_in_request       = out_sir_reg;
    assign rsp.request_last          = out_rlast_reg;
    assign rsp.list_done             = out_done_reg;
    assign rsp.missing_count         = out_mc_reg;
    assign rsp.missing_below_highest = out_mbh_reg;
    assign rsp.request_count         = out_rc_reg;
    assign rsp.highest_id            = out_high_reg;

    // a taken request word keeps the channel closed on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> !req.ready)
        else $error("request taken while previous one still in work");

    // a map write is never followed at once by a read of the map
    a_no_read_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> !rd_en)
        else $error("map read overlaps a pending write");

    // a result never reports both a new and a duplicate arrival
    a_acc_dup_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.accepted && rsp.duplicate))
        else $error("arrival both accepted and duplicate");

    // request position stays below the widest request size
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg != 5'd31)
        else $error("request position out of range");

    // the divider runs exactly nine steps
    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (div_cnt_reg <= 4'd8))
        else $error("division step count overrun");

endmodule
